// ===== rtl/core/scfr_pkg.sv =====
// Shared types and constants of the serial command frame receiver.
`timescale 1ns / 1ps

package scfr_pkg;

  localparam int unsigned FrameBytes   = 17;
  localparam int unsigned PosW         = $clog2(FrameBytes);
  localparam int unsigned PosTail      = FrameBytes - 1;
  localparam int unsigned PosCheck     = 15;
  localparam int unsigned PosCheckLast = 14;
  localparam int unsigned PosVx        = 3;
  localparam int unsigned PosVy        = 7;
  localparam int unsigned PosWz        = 11;
  localparam int unsigned WordBytes    = PosCheckLast - PosVx + 1;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusTail  = 2'd1;
  localparam logic [1:0] StatusCheck = 2'd2;

  localparam logic CfgHead = 1'b0;
  localparam logic CfgTail = 1'b1;

  localparam logic [7:0] HeadReset = 8'd170;
  localparam logic [7:0] TailReset = 8'd85;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned OutDataW = 104;

  typedef struct packed {
    logic [7:0]      data;
    logic [PosW-1:0] pos;
  } q_entry_t;

  typedef struct packed {
    logic [31:0] wz;
    logic [31:0] vy;
    logic [31:0] vx;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== rtl/core/scfr_front.sv =====
// Front end: header hunt, byte position tracking and queue push.
`timescale 1ns / 1ps

module scfr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [7:0]                byte_i,
  input  logic [7:0]                head_byte_i,
  input  logic                      q_full_i,
  output logic                      ready_o,
  output logic                      push_o,
  output scfr_pkg::q_entry_t        entry_o
);

  logic [scfr_pkg::PosW-1:0] pos_q, pos_d;
  logic                      accept;
  logic                      keep;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  // at the idle position only the header byte opens a frame
  assign keep    = (pos_q != '0) || (byte_i == head_byte_i);
  assign push_o  = accept && keep;

  assign entry_o.data = byte_i;
  assign entry_o.pos  = pos_q;

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (pos_q == scfr_pkg::PosW'(scfr_pkg::PosTail)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== rtl/core/scfr_queue.sv =====
// Short queue of classified bytes between front and back end.
`timescale 1ns / 1ps

module scfr_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  scfr_pkg::q_entry_t        entry_i,
  input  logic                      pop_i,
  output logic                      full_o,
  output logic                      valid_o,
  output scfr_pkg::q_entry_t        entry_o
);

  scfr_pkg::q_entry_t              mem_q [scfr_pkg::QDepth];
  logic [scfr_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [scfr_pkg::QCntW-1:0]      cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == scfr_pkg::QCntW'(scfr_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/scfr_back.sv =====
// Back end: frame assembly, XOR check, tail check and result register.
`timescale 1ns / 1ps

module scfr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  scfr_pkg::q_entry_t        q_entry_i,
  output logic                      q_pop_o,
  input  logic [7:0]                tail_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output scfr_pkg::result_t         result_o
);

  logic [7:0]        word_q [scfr_pkg::WordBytes];
  logic [7:0]        check_byte_q;
  logic [7:0]        xor_q, xor_d;
  logic              out_valid_q;
  scfr_pkg::result_t result_q, result_d;
  logic              out_free;
  logic              is_tail;

  assign is_tail  = (q_entry_i.pos == scfr_pkg::PosW'(scfr_pkg::PosTail));
  assign out_free = !out_valid_q || out_ready_i;
  // hold a finished frame in the queue until the result slot frees up
  assign q_pop_o  = q_valid_i && (!is_tail || out_free);

  always_comb begin
    xor_d = xor_q;
    if (q_entry_i.pos == '0) begin
      xor_d = '0;
    end else if (q_entry_i.pos <= scfr_pkg::PosW'(scfr_pkg::PosCheckLast)) begin
      xor_d = xor_q ^ q_entry_i.data;
    end
  end

  always_comb begin
    result_d        = '0;
    result_d.status = scfr_pkg::StatusOk;
    if (q_entry_i.data != tail_byte_i) begin
      result_d.status = scfr_pkg::StatusTail;
    end else if (xor_q != check_byte_q) begin
      result_d.status = scfr_pkg::StatusCheck;
    end else begin
      result_d.vx = {word_q[3], word_q[2], word_q[1], word_q[0]};
      result_d.vy = {word_q[7], word_q[6], word_q[5], word_q[4]};
      result_d.wz = {~word_q[11][7], word_q[11][6:0], word_q[10], word_q[9], word_q[8]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int i = 0; i < scfr_pkg::WordBytes; i++) begin
        if (q_entry_i.pos == scfr_pkg::PosW'(scfr_pkg::PosVx + i)) begin
          word_q[i] <= q_entry_i.data;
        end
      end
      if (q_entry_i.pos == scfr_pkg::PosW'(scfr_pkg::PosCheck)) begin
        check_byte_q <= q_entry_i.data;
      end
    end
    if (q_pop_o && is_tail) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        xor_q <= xor_d;
      end
      if (q_pop_o && is_tail) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ===== rtl/core/serial_command_frame_receiver_core.sv =====
// Top level of the serial command frame receiver.
//
//   channel  dir  handshake                      payload
//   s_axis   in   s_axis_tvalid / s_axis_tready  tdata[7:0] rx_byte
//   m_axis   out  m_axis_tvalid / m_axis_tready  tdata: status, vx, vy, wz
//   cfg      in   cfg_we_i (no back-pressure)    cfg_idx_i, cfg_data_i
//
// One byte is taken per cycle; the front end only stalls when the four-entry
// byte queue is full. The closing byte of a frame waits in the queue while the
// single result register is occupied, so a stalled master backs up the queue
// and then the slave side. A frame's tail byte is written into the queue, and
// its result is registered when that byte leaves the queue head. Reset clears
// the position counter, the running XOR, the queue and the result valid; head
// and tail bytes return to 0xAA and 0x55.
// Frame byte storage needs no clearing: every byte is written before it is read.
`timescale 1ns / 1ps

module serial_command_frame_receiver_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side, tdata: rx_byte[7:0]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,
  // master side, tdata: frame_status[1:0], vx_bits[33:2], vy_bits[65:34],
  // wz_bits[97:66], zero fill [103:98]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [scfr_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [7:0]                     cfg_data_i
);

  logic [7:0]          head_byte_q, tail_byte_q;
  logic                q_full, q_valid, q_pop, push;
  scfr_pkg::q_entry_t  push_entry, head_entry;
  scfr_pkg::result_t   result;

  // register file: takes effect on the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_byte_q <= scfr_pkg::HeadReset;
      tail_byte_q <= scfr_pkg::TailReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scfr_pkg::CfgHead: head_byte_q <= cfg_data_i;
        scfr_pkg::CfgTail: tail_byte_q <= cfg_data_i;
        default:           head_byte_q <= head_byte_q;
      endcase
    end
  end

  // hunt for the header and tag each kept byte with its frame position
  scfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .byte_i      (s_axis_tdata),
    .head_byte_i (head_byte_q),
    .q_full_i    (q_full),
    .ready_o     (s_axis_tready),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // decouple byte intake from result delivery
  scfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  // assemble the frame, run both checks, register the result
  scfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .tail_byte_i (tail_byte_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {{(scfr_pkg::OutDataW - $bits(result)){1'b0}}, result};

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the serial command frame receiver core.
`timescale 1ns / 1ps

module tb;
  import scfr_pkg::*;

  localparam int unsigned TargetBytes = 1450;   // frame bytes the block consumes
  localparam int unsigned DrainCycles = 16;     // byte queue plus result pipeline
  localparam int unsigned HoldCycles  = 400;    // long receiver hold-off
  localparam int unsigned CycleLimit  = 200000;

  typedef enum logic [2:0] {
    FrameGood,
    FrameBadTail,
    FrameBadCheck,
    FrameBadBoth,
    FrameCut
  } frame_kind_e;

  logic                clk           = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = CfgHead;
  logic [7:0]          cfg_data_i    = 8'h00;

  // Frame assembler copy and register shadows.
  logic [7:0]      frame_bytes [FrameBytes];
  logic [PosW-1:0] next_pos = '0;
  logic [7:0]      xor_acc  = 8'h00;
  logic [7:0]      head_val = HeadReset;
  logic [7:0]      tail_val = TailReset;
  result_t         expected_frames [$];

  int unsigned frame_byte_cnt = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned rx_hold_cycles = 0;
  bit          idle_on        = 1'b1;

  serial_command_frame_receiver_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic logic [31:0] le_word(input int unsigned at);
    return {frame_bytes[at + 3], frame_bytes[at + 2], frame_bytes[at + 1], frame_bytes[at]};
  endfunction

  // Advance the frame assembler by one accepted byte; queue a result when a frame closes.
  function automatic void predict_byte(input logic [7:0] b);
    result_t     r;
    int unsigned p;
    p = next_pos;
    if (p >= FrameBytes) p = 0;
    if (p == 0) begin
      if (b != head_val) return;
      xor_acc = 8'h00;
    end else if (p <= PosCheckLast) begin
      xor_acc ^= b;
    end
    frame_bytes[p] = b;
    frame_byte_cnt++;
    p++;
    if (p < FrameBytes) begin
      next_pos = PosW'(p);
      return;
    end
    next_pos = '0;
    r = '0;
    r.status = StatusOk;
    if (frame_bytes[PosTail] != tail_val) begin
      r.status = StatusTail;
    end else if (xor_acc != frame_bytes[PosCheck]) begin
      r.status = StatusCheck;
    end else begin
      r.vx = le_word(PosVx);
      r.vy = le_word(PosVy);
      r.wz = le_word(PosWz) ^ 32'h8000_0000;
    end
    expected_frames.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic logic [7:0] pick_reg_value(input logic [7:0] dflt);
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return dflt;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte, after a random gap if idle_on is set; hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    predict_byte(b);
  endtask

  // Stop offering, wait for every pending result, then let the byte queue empty.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    settle_block();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    if (idx == CfgHead) head_val = val;
    else tail_val = val;
  endtask

  // Build one frame with random payload; optionally rewrite a register partway through.
  task automatic send_frame(input frame_kind_e kind, input bit mid_write);
    logic [7:0]  fb [FrameBytes];
    logic [7:0]  eff_tail;
    logic [7:0]  new_val;
    logic [7:0]  sum;
    logic        cfg_sel;
    int unsigned len;
    int unsigned split_at;
    cfg_sel  = logic'($urandom_range(0, 1));
    new_val  = 8'($urandom);
    split_at = $urandom_range(1, FrameBytes - 1);
    eff_tail = (mid_write && cfg_sel == CfgTail) ? new_val : tail_val;
    fb[0] = head_val;
    sum   = 8'h00;
    for (int i = 1; i <= PosCheckLast; i++) begin
      case ($urandom_range(0, 9))
        0: fb[i] = head_val;
        1: fb[i] = 8'h00;
        2: fb[i] = 8'hFF;
        default: fb[i] = 8'($urandom);
      endcase
      sum ^= fb[i];
    end
    fb[PosCheck] = sum;
    fb[PosTail]  = eff_tail;
    if (kind == FrameBadTail || kind == FrameBadBoth) fb[PosTail] ^= 8'($urandom_range(1, 255));
    if (kind == FrameBadCheck || kind == FrameBadBoth) fb[PosCheck] ^= 8'($urandom_range(1, 255));
    len = (kind == FrameCut) ? $urandom_range(1, FrameBytes - 1) : FrameBytes;
    for (int i = 0; i < len; i++) begin
      if (mid_write && i == split_at) write_reg(cfg_sel, new_val);
      send_byte(fb[i]);
    end
  endtask

  // Noise ahead of the header, then one frame at reset settings with extreme payload.
  task automatic test_header_hunt();
    logic [7:0] b;
    logic [7:0] sum;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(head_val ^ 8'h01);
    send_byte(head_val);
    sum = 8'h00;
    for (int i = 1; i <= PosCheckLast; i++) begin
      if (i == 1 || (i >= PosVy && i < PosWz)) b = 8'hFF;
      else if (i == 2) b = head_val;
      else if (i == PosCheckLast) b = 8'h80;
      else b = 8'h00;
      sum ^= b;
      send_byte(b);
    end
    send_byte(sum);
    send_byte(tail_val);
    settle_block();
  endtask

  // Phases of random frames under changing register settings and idle patterns.
  task automatic test_random_frames();
    frame_kind_e kind;
    logic [7:0]  noise;
    int unsigned roll;
    int unsigned frames;
    while (frame_byte_cnt < TargetBytes) begin
      write_reg(CfgHead, pick_reg_value(HeadReset));
      write_reg(CfgTail, pick_reg_value(TailReset));
      idle_on = ($urandom_range(0, 3) != 0);
      frames  = $urandom_range(4, 12);
      repeat (frames) begin
        repeat ($urandom_range(0, 2)) begin
          noise = 8'($urandom);
          if (noise == head_val) noise ^= 8'h01;
          send_byte(noise);
        end
        roll = $urandom_range(0, 19);
        if (roll < 12) kind = FrameGood;
        else if (roll < 14) kind = FrameBadTail;
        else if (roll < 16) kind = FrameBadCheck;
        else if (roll < 17) kind = FrameBadBoth;
        else kind = FrameCut;
        send_frame(kind, $urandom_range(0, 9) == 0);
      end
    end
    idle_on = 1'b1;
  endtask

  // Hold the receiver off while frames stream in back to back, then drain.
  task automatic test_backpressure();
    idle_on        = 1'b0;
    rx_hold_cycles = HoldCycles;
    repeat (5) send_frame(FrameGood, 1'b0);
    settle_block();
    idle_on = 1'b1;
  endtask

  // Result side: random stalls, optional long hold-off, compare against oldest frame.
  initial begin : result_checker
    int unsigned stall;
    bit          got_item;
    result_t     want;
    result_t     got;
    while (!rst_ni) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      got_item = 1'b0;
      while (!got_item) begin
        @(posedge clk);
        if (m_axis_tvalid) begin
          got_item = 1'b1;
        end else if (rx_hold_cycles != 0) begin
          m_axis_tready <= 1'b0;
          repeat (rx_hold_cycles) @(posedge clk);
          rx_hold_cycles = 0;
          m_axis_tready <= 1'b1;
        end
      end
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (expected_frames.size() == 0) begin
        $display("%0t: result with no frame pending, expected none, got %h", $time,
                 m_axis_tdata);
        mismatch_cnt++;
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_status", 32'(want.status), 32'(got.status));
        check_field("vx_bits", want.vx, got.vx);
        check_field("vy_bits", want.vy, got.vy);
        check_field("wz_bits", want.wz, got.wz);
        check_field("zero fill", 32'h0, 32'(m_axis_tdata[OutDataW-1:$bits(result_t)]));
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_header_hunt();
    test_random_frames();
    test_backpressure();
    settle_block();
    if (mismatch_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== serial_command_frame_receiver_core.f =====
rtl/core/scfr_pkg.sv
rtl/core/scfr_front.sv
rtl/core/scfr_queue.sv
rtl/core/scfr_back.sv
rtl/core/serial_command_frame_receiver_core.sv
test/tb.sv
